@@ rtl/core/asm_pkg.sv @@
// ----------------------------------------------------------------------------
// asm_pkg
// shared widths, operation codes and statistic indexes of the allocation
// statistics monitor
// ----------------------------------------------------------------------------
package asm_pkg;

	localparam int OP_W    = 3;
	localparam int SIZE_W  = 48;
	localparam int LIFE_W  = 64;
	localparam int ID_W    = 32;
	localparam int SEL_W   = 5;
	localparam int STAT_W  = 64;

	// payload bits without padding, then rounded up to whole bytes
	localparam int IN_BITS   = 2 * SIZE_W + LIFE_W + ID_W + SEL_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [SIZE_W-1:0] size_t;
	typedef logic [LIFE_W-1:0] life_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [SEL_W-1:0]  sel_t;
	typedef logic [STAT_W-1:0] stat_t;

	localparam op_t OP_ALLOC   = 3'd0;
	localparam op_t OP_FREE    = 3'd1;
	localparam op_t OP_LFREE   = 3'd2;
	localparam op_t OP_REALLOC = 3'd3;
	localparam op_t OP_READ    = 3'd4;

	localparam sel_t SEL_ALLOC_COUNT  = 5'd0;
	localparam sel_t SEL_ALLOC_MIN    = 5'd1;
	localparam sel_t SEL_ALLOC_MAX    = 5'd2;
	localparam sel_t SEL_ALLOC_SUM    = 5'd3;
	localparam sel_t SEL_FREE_COUNT   = 5'd4;
	localparam sel_t SEL_FREE_MIN     = 5'd5;
	localparam sel_t SEL_FREE_MAX     = 5'd6;
	localparam sel_t SEL_FREE_SUM     = 5'd7;
	localparam sel_t SEL_LIFE_COUNT   = 5'd8;
	localparam sel_t SEL_LIFE_MIN     = 5'd9;
	localparam sel_t SEL_LIFE_MAX     = 5'd10;
	localparam sel_t SEL_LIFE_SUM     = 5'd11;
	localparam sel_t SEL_LIVE_BYTES   = 5'd12;
	localparam sel_t SEL_LIVE_MAX     = 5'd13;
	localparam sel_t SEL_ZERO_COUNT   = 5'd14;
	localparam sel_t SEL_PEAK_LIVE    = 5'd15;
	localparam sel_t SEL_PEAK_INDEX   = 5'd16;
	localparam sel_t SEL_RESIZE_COUNT = 5'd17;
	localparam sel_t SEL_RESIZE_DELTA = 5'd18;

	// input item as held in the first stage
	typedef struct packed {
		op_t   operation;
		size_t size;
		size_t old_size;
		life_t lifetime;
		id_t   peak_id;
		sel_t  stat_select;
	} item_t;

endpackage

@@ rtl/core/allocation_statistics_monitor.sv @@
// ----------------------------------------------------------------------------
// allocation_statistics_monitor
// per-site allocation statistics: counts, min/max/sum, live bytes and peak
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                                 | tuser
//  s_*     | in  | size, old_size, lifetime, peak_id, stat_select, pad | operation
//  m_*     | out | read_data                                          | -
//
//  one item per cycle while no read stalls; an item is held in the input
//  register and updates the statistics registers at the following edge
//  a read result passes from the input register into the output register
//  arst_n clears every statistic and both stage valids
//  a read waiting in the input register stalls the input side while the
//  output register is full and not taken; other items never stall
// ----------------------------------------------------------------------------
module allocation_statistics_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// size[47:0], old_size[95:48], lifetime[159:96], peak_id[191:160],
	// stat_select[196:192], zero pad
	input  logic [asm_pkg::IN_DATA_W-1:0] s_tdata,
	// operation[2:0]
	input  logic [asm_pkg::OP_W-1:0]      s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_data[63:0]
	output logic [asm_pkg::STAT_W-1:0]    m_tdata
);

	localparam int SW = asm_pkg::SIZE_W;

	logic           valid_s1;
	asm_pkg::item_t item_s1;
	logic           stall_s1;
	logic           fire_s1;

	asm_pkg::stat_t alloc_count_q, alloc_sum_q;
	asm_pkg::size_t alloc_min_q, alloc_max_q;
	asm_pkg::stat_t free_count_q, free_sum_q;
	asm_pkg::size_t free_min_q, free_max_q;
	asm_pkg::stat_t life_count_q, life_min_q, life_max_q, life_sum_q;
	asm_pkg::stat_t live_bytes_q, live_max_q, zero_count_q, peak_live_q;
	asm_pkg::id_t   peak_index_q;
	asm_pkg::stat_t resize_count_q, resize_delta_q;

	logic           out_valid_q;
	asm_pkg::stat_t out_data_q;

	logic           size_zero;
	logic           peak_newer;
	asm_pkg::stat_t size_ext;
	asm_pkg::stat_t live_add;
	asm_pkg::stat_t live_sub;
	asm_pkg::size_t delta;
	asm_pkg::stat_t read_val;
	logic           is_read;

	assign is_read  = item_s1.operation == asm_pkg::OP_READ;
	assign stall_s1 = valid_s1 && is_read && out_valid_q && !m_tready;
	assign fire_s1  = valid_s1 && !stall_s1;
	assign s_tready = !valid_s1 || !stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation   <= s_tuser;
			item_s1.size        <= s_tdata[SW-1:0];
			item_s1.old_size    <= s_tdata[2*SW-1:SW];
			item_s1.lifetime    <= s_tdata[2*SW+asm_pkg::LIFE_W-1:2*SW];
			item_s1.peak_id     <= s_tdata[2*SW+asm_pkg::LIFE_W+asm_pkg::ID_W-1:
				2*SW+asm_pkg::LIFE_W];
			item_s1.stat_select <= s_tdata[asm_pkg::IN_BITS-1:
				asm_pkg::IN_BITS-asm_pkg::SEL_W];
		end
	end

	assign size_zero  = item_s1.size == '0;
	assign peak_newer = item_s1.peak_id > peak_index_q;
	assign size_ext   = {{(asm_pkg::STAT_W-SW){1'b0}}, item_s1.size};
	assign live_add   = live_bytes_q + size_ext;
	// linked free saturates at zero
	assign live_sub   = (live_bytes_q >= size_ext) ? live_bytes_q - size_ext : '0;
	assign delta      = (item_s1.old_size > item_s1.size) ?
		item_s1.old_size - item_s1.size : item_s1.size - item_s1.old_size;

	always_comb begin
		unique case (item_s1.stat_select)
			asm_pkg::SEL_ALLOC_COUNT:  read_val = alloc_count_q;
			asm_pkg::SEL_ALLOC_MIN:    read_val = {{(asm_pkg::STAT_W-SW){1'b0}}, alloc_min_q};
			asm_pkg::SEL_ALLOC_MAX:    read_val = {{(asm_pkg::STAT_W-SW){1'b0}}, alloc_max_q};
			asm_pkg::SEL_ALLOC_SUM:    read_val = alloc_sum_q;
			asm_pkg::SEL_FREE_COUNT:   read_val = free_count_q;
			asm_pkg::SEL_FREE_MIN:     read_val = {{(asm_pkg::STAT_W-SW){1'b0}}, free_min_q};
			asm_pkg::SEL_FREE_MAX:     read_val = {{(asm_pkg::STAT_W-SW){1'b0}}, free_max_q};
			asm_pkg::SEL_FREE_SUM:     read_val = free_sum_q;
			asm_pkg::SEL_LIFE_COUNT:   read_val = life_count_q;
			asm_pkg::SEL_LIFE_MIN:     read_val = life_min_q;
			asm_pkg::SEL_LIFE_MAX:     read_val = life_max_q;
			asm_pkg::SEL_LIFE_SUM:     read_val = life_sum_q;
			asm_pkg::SEL_LIVE_BYTES:   read_val = live_bytes_q;
			asm_pkg::SEL_LIVE_MAX:     read_val = live_max_q;
			asm_pkg::SEL_ZERO_COUNT:   read_val = zero_count_q;
			asm_pkg::SEL_PEAK_LIVE:    read_val = peak_live_q;
			asm_pkg::SEL_PEAK_INDEX:   read_val = {{(asm_pkg::STAT_W-asm_pkg::ID_W){1'b0}},
				peak_index_q};
			asm_pkg::SEL_RESIZE_COUNT: read_val = resize_count_q;
			asm_pkg::SEL_RESIZE_DELTA: read_val = resize_delta_q;
			default:                   read_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_count_q  <= '0;
			alloc_min_q    <= '0;
			alloc_max_q    <= '0;
			alloc_sum_q    <= '0;
			free_count_q   <= '0;
			free_min_q     <= '0;
			free_max_q     <= '0;
			free_sum_q     <= '0;
			life_count_q   <= '0;
			life_min_q     <= '0;
			life_max_q     <= '0;
			life_sum_q     <= '0;
			live_bytes_q   <= '0;
			live_max_q     <= '0;
			zero_count_q   <= '0;
			peak_live_q    <= '0;
			peak_index_q   <= '0;
			resize_count_q <= '0;
			resize_delta_q <= '0;
		end else if (fire_s1) begin
			unique case (item_s1.operation)
				asm_pkg::OP_ALLOC: begin
					if (size_zero) begin
						zero_count_q <= zero_count_q + 64'd1;
					end else begin
						if (alloc_count_q == '0) begin
							alloc_min_q <= item_s1.size;
							alloc_max_q <= item_s1.size;
						end else begin
							if (item_s1.size < alloc_min_q) alloc_min_q <= item_s1.size;
							if (item_s1.size > alloc_max_q) alloc_max_q <= item_s1.size;
						end
						alloc_count_q <= alloc_count_q + 64'd1;
						alloc_sum_q   <= alloc_sum_q + size_ext;
					end
					// peak snapshot takes live bytes before this item's add
					if (peak_newer) begin
						peak_index_q <= item_s1.peak_id;
						peak_live_q  <= live_bytes_q;
					end
					live_bytes_q <= live_add;
					if (live_add > live_max_q) live_max_q <= live_add;
				end
				asm_pkg::OP_FREE: begin
					if (size_zero) begin
						zero_count_q <= zero_count_q + 64'd1;
					end else begin
						if (peak_newer) begin
							peak_index_q <= item_s1.peak_id;
							peak_live_q  <= live_bytes_q;
						end
						if (free_count_q == '0) begin
							free_min_q <= item_s1.size;
							free_max_q <= item_s1.size;
						end else begin
							if (item_s1.size < free_min_q) free_min_q <= item_s1.size;
							if (item_s1.size > free_max_q) free_max_q <= item_s1.size;
						end
						free_count_q <= free_count_q + 64'd1;
						free_sum_q   <= free_sum_q + size_ext;
					end
				end
				asm_pkg::OP_LFREE: begin
					if (peak_newer) begin
						peak_index_q <= item_s1.peak_id;
						peak_live_q  <= live_bytes_q;
					end
					live_bytes_q <= live_sub;
					if (item_s1.lifetime != '0) begin
						if (life_count_q == '0) begin
							life_min_q <= item_s1.lifetime;
							life_max_q <= item_s1.lifetime;
						end else begin
							if (item_s1.lifetime < life_min_q) life_min_q <= item_s1.lifetime;
							if (item_s1.lifetime > life_max_q) life_max_q <= item_s1.lifetime;
						end
						life_count_q <= life_count_q + 64'd1;
						life_sum_q   <= life_sum_q + item_s1.lifetime;
					end
				end
				asm_pkg::OP_REALLOC: begin
					resize_count_q <= resize_count_q + 64'd1;
					resize_delta_q <= resize_delta_q +
						{{(asm_pkg::STAT_W-SW){1'b0}}, delta};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && is_read) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_read) begin
			out_data_q <= read_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ rtl/core/asm_checker.sv @@
// ----------------------------------------------------------------------------
// asm_checker
// port-level checks of the allocation statistics monitor, bound to the top
// ----------------------------------------------------------------------------
module asm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [asm_pkg::IN_DATA_W-1:0] s_tdata,
	input logic [asm_pkg::OP_W-1:0]      s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [asm_pkg::STAT_W-1:0]    m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a fresh result always comes from an accepted read item
	a_rise_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready &&
			s_tuser == asm_pkg::OP_READ, 2))
		else $error("result without a read item");

	// a non-read item into an empty pipe never shows up as a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tvalid && s_tready && s_tuser == asm_pkg::OP_READ)
		##1 !m_tvalid && s_tvalid && s_tready && s_tuser != asm_pkg::OP_READ
		##1 !(s_tvalid && s_tready && s_tuser == asm_pkg::OP_READ) |=> !m_tvalid)
		else $error("result from a non-read item");

	// the input side is open whenever no result is held
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// once reset has been seen at an edge, no result is offered while it lasts
	a_reset_out: assert property (@(posedge clk)
		!arst_n ##1 !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind allocation_statistics_monitor asm_checker u_asm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the allocation statistics monitor: a queue-fed driver
// sends alloc, free, linked free, realloc and read items, a shadow copy of
// the statistics predicts every read, and a monitor checks the read results
// in order
// ----------------------------------------------------------------------------
module tb_top;
	import asm_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int OLD_LSB    = SIZE_W;
	localparam int LIFE_LSB   = 2 * SIZE_W;
	localparam int ID_LSB     = LIFE_LSB + LIFE_W;
	localparam int SEL_LSB    = ID_LSB + ID_W;
	localparam int PAD_W      = IN_DATA_W - IN_BITS;

	localparam size_t SIZE_ALL = '1;
	localparam life_t LIFE_ALL = '1;
	localparam id_t   ID_ALL   = '1;

	typedef struct packed {
		logic [63:0] count;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] total;
	} tally_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata  = '0;
	logic [OP_W-1:0]      s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [STAT_W-1:0]    m_tdata;

	allocation_statistics_monitor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// shadow statistics
	tally_t      allocs, frees, lifetimes;
	logic [63:0] live, live_top, zero_sizes, peak_bytes, resizes, resize_total;
	id_t         peak_seen;

	item_t pending_items[$];
	stat_t expected_reads[$];

	bit   in_taken;
	bit   calm;
	int   send_gap, recv_gap, hold_left;
	int   send_idle_pct, recv_idle_pct, read_pct;
	int   long_hold_cycles;
	int   error_count;
	id_t  peak_cursor;

	initial forever #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#4_800_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic tally_t tally_add(tally_t t, logic [63:0] v);
		tally_t r;
		r = t;
		if (t.count == 0) begin
			r.lo = v;
			r.hi = v;
		end else begin
			if (v < t.lo)
				r.lo = v;
			if (v > t.hi)
				r.hi = v;
		end
		r.count = t.count + 64'd1;
		r.total = t.total + v;
		return r;
	endfunction

	// a newer peak index snapshots live bytes before this item changes them
	task automatic note_peak(id_t id);
		if (peak_seen < id) begin
			peak_seen  = id;
			peak_bytes = live;
		end
	endtask

	task automatic apply_event(item_t it);
		logic [63:0] sz;
		stat_t       value;
		sz = 64'(it.size);
		case (it.operation)
			OP_ALLOC: begin
				if (sz == 0)
					zero_sizes = zero_sizes + 64'd1;
				else
					allocs = tally_add(allocs, sz);
				note_peak(it.peak_id);
				live = live + sz;
				if (live > live_top)
					live_top = live;
			end
			OP_FREE: begin
				if (sz == 0) begin
					zero_sizes = zero_sizes + 64'd1;
				end else begin
					note_peak(it.peak_id);
					frees = tally_add(frees, sz);
				end
			end
			OP_LFREE: begin
				note_peak(it.peak_id);
				live = (live >= sz) ? live - sz : 64'd0;
				if (it.lifetime != 0)
					lifetimes = tally_add(lifetimes, it.lifetime);
			end
			OP_REALLOC: begin
				resizes = resizes + 64'd1;
				resize_total = resize_total + ((it.old_size > it.size) ?
					64'(it.old_size - it.size) : 64'(it.size - it.old_size));
			end
			OP_READ: begin
				case (it.stat_select)
					SEL_ALLOC_COUNT:  value = allocs.count;
					SEL_ALLOC_MIN:    value = allocs.lo;
					SEL_ALLOC_MAX:    value = allocs.hi;
					SEL_ALLOC_SUM:    value = allocs.total;
					SEL_FREE_COUNT:   value = frees.count;
					SEL_FREE_MIN:     value = frees.lo;
					SEL_FREE_MAX:     value = frees.hi;
					SEL_FREE_SUM:     value = frees.total;
					SEL_LIFE_COUNT:   value = lifetimes.count;
					SEL_LIFE_MIN:     value = lifetimes.lo;
					SEL_LIFE_MAX:     value = lifetimes.hi;
					SEL_LIFE_SUM:     value = lifetimes.total;
					SEL_LIVE_BYTES:   value = live;
					SEL_LIVE_MAX:     value = live_top;
					SEL_ZERO_COUNT:   value = zero_sizes;
					SEL_PEAK_LIVE:    value = peak_bytes;
					SEL_PEAK_INDEX:   value = 64'(peak_seen);
					SEL_RESIZE_COUNT: value = resizes;
					SEL_RESIZE_DELTA: value = resize_total;
					default:          value = '0;
				endcase
				expected_reads.push_back(value);
			end
			default: ;
		endcase
	endtask

	task automatic report_error(string what, stat_t want, stat_t got);
		if (error_count < 10)
			$display("ERROR at %0t: %s, expected %h, got %h", $realtime, what, want, got);
		error_count++;
	endtask

	function automatic item_t make_item(op_t op, size_t sz, size_t old, life_t life,
		id_t id, sel_t sel);
		item_t it;
		it.operation   = op;
		it.size        = sz;
		it.old_size    = old;
		it.lifetime    = life;
		it.peak_id     = id;
		it.stat_select = sel;
		return it;
	endfunction

	function automatic size_t random_size();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return SIZE_ALL;
		else if (pick < 8)
			return size_t'($urandom_range(1, 4096));
		return size_t'({$urandom, $urandom});
	endfunction

	function automatic life_t random_life();
		int pick;
		pick = $urandom_range(0, 11);
		if (pick < 2)
			return '0;
		else if (pick == 2)
			return LIFE_ALL;
		else if (pick < 7)
			return life_t'($urandom_range(1, 100000));
		return {$urandom, $urandom};
	endfunction

	function automatic item_t random_event();
		item_t it;
		int    pick;
		it = make_item(OP_READ, random_size(), random_size(), random_life(), $urandom,
			sel_t'($urandom_range(0, 31)));
		pick = $urandom_range(0, 99);
		if (pick < read_pct) begin
			// mostly defined statistics, some unused selectors
			if ($urandom_range(0, 4) == 0)
				it.stat_select = sel_t'($urandom_range(SEL_RESIZE_DELTA + 1, 31));
			else
				it.stat_select = sel_t'($urandom_range(0, SEL_RESIZE_DELTA));
		end else if (pick < read_pct + 4) begin
			it.operation = op_t'(OP_READ + $urandom_range(1, 3));
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: it.operation = OP_ALLOC;
				4, 5:       it.operation = OP_FREE;
				6, 7, 8:    it.operation = OP_LFREE;
				default:    it.operation = OP_REALLOC;
			endcase
			// peak ids creep upward with some stale repeats
			if (it.operation != OP_REALLOC) begin
				peak_cursor = peak_cursor + id_t'($urandom_range(0, 2));
				it.peak_id  = peak_cursor - id_t'($urandom_range(0, 1));
			end
		end
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || expected_reads.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_batch(int count, int snd_pct, int rcv_pct, int rd_pct);
		item_t it;
		int    n;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		read_pct      = rd_pct;
		n = 0;
		while (n < count) begin
			it = random_event();
			pending_items.push_back(it);
			if (it.operation <= OP_READ)
				n++;
		end
		wait_drained();
	endtask

	// input side: predict every accepted item
	always @(posedge clk) begin
		item_t seen;
		if (arst_n && s_tvalid && s_tready) begin
			seen.operation   = s_tuser;
			seen.size        = s_tdata[SIZE_W-1:0];
			seen.old_size    = s_tdata[OLD_LSB +: SIZE_W];
			seen.lifetime    = s_tdata[LIFE_LSB +: LIFE_W];
			seen.peak_id     = s_tdata[ID_LSB +: ID_W];
			seen.stat_select = s_tdata[SEL_LSB +: SEL_W];
			apply_event(seen);
			in_taken = 1'b1;
		end
	end

	// output side: check read results in order
	always @(posedge clk) begin
		stat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_reads.size() == 0) begin
				report_error("read result with no read pending", '0, m_tdata);
			end else begin
				want = expected_reads.pop_front();
				if (m_tdata !== want)
					report_error("read_data mismatch", want, m_tdata);
			end
		end
	end

	always @(negedge clk) begin
		item_t nxt;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				nxt = pending_items.pop_front();
				s_tdata  <= {PAD_W'(0), nxt.stat_select, nxt.peak_id, nxt.lifetime,
					nxt.old_size, nxt.size};
				s_tuser  <= nxt.operation;
				s_tvalid <= 1'b1;
				if (!calm && $urandom_range(0, 99) < send_idle_pct)
					send_gap = $urandom_range(1, 11);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (long_hold_cycles > 0) begin
			hold_left        = long_hold_cycles;
			long_hold_cycles = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < recv_idle_pct)
				recv_gap = $urandom_range(1, 11);
		end
	end

	initial begin
		int k;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values, then the corner cases one at a time
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_ALLOC_MIN));
		pending_items.push_back(make_item(OP_ALLOC, '0, SIZE_ALL, '0, '0, '1));
		pending_items.push_back(make_item(OP_ALLOC, SIZE_ALL, '0, '0, 1, '0));
		pending_items.push_back(make_item(OP_ALLOC, 1, '0, LIFE_ALL, 1, '0));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_PEAK_LIVE));
		// zero free leaves the peak alone even with a newer index
		pending_items.push_back(make_item(OP_FREE, '0, '0, '0, ID_ALL, '0));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_PEAK_INDEX));
		pending_items.push_back(make_item(OP_FREE, SIZE_ALL, '0, '0, 2, '0));
		pending_items.push_back(make_item(OP_FREE, 1, '0, '0, 2, '0));
		pending_items.push_back(make_item(OP_LFREE, 5, '0, '0, 3, '0));
		// larger than live bytes: saturates at zero
		pending_items.push_back(make_item(OP_LFREE, SIZE_ALL, '0, LIFE_ALL, 3, '0));
		pending_items.push_back(make_item(OP_LFREE, 7, '0, 1, 3, '0));
		pending_items.push_back(make_item(OP_REALLOC, '0, SIZE_ALL, '0, '0, '0));
		pending_items.push_back(make_item(OP_REALLOC, SIZE_ALL, '0, '0, '0, '0));
		pending_items.push_back(make_item(OP_REALLOC, 9, 9, '0, '0, '0));
		for (k = 1; k <= 3; k++)
			pending_items.push_back(make_item(op_t'(OP_READ + k), 1, 1, 1, 4, '0));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_LIVE_BYTES));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_LIVE_MAX));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_LIFE_MIN));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_LIFE_MAX));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_FREE_MIN));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_RESIZE_DELTA));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_ZERO_COUNT));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, SEL_RESIZE_DELTA + 1));
		pending_items.push_back(make_item(OP_READ, '0, '0, '0, '0, '1));
		wait_drained();

		peak_cursor = 4;
		run_batch(400, 10, 10, 30);
		// receiver holds off while reads keep coming, so the input side stalls
		long_hold_cycles = 300;
		run_batch(200, 5, 0, 50);
		run_batch(400, 30, 30, 30);
		run_batch(300, 0, 25, 30);
		// last stretch at full rate, with peak indexes up in the high bits
		calm        = 1'b1;
		peak_cursor = 32'hFFFF_0000;
		run_batch(300, 0, 0, 30);
		repeat (8) @(posedge clk);

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ allocation_statistics_monitor.f @@
rtl/core/asm_pkg.sv
rtl/core/allocation_statistics_monitor.sv
rtl/core/asm_checker.sv
tb/tb_top.sv
